// ===== rtl/aarm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared types, widths, defaults and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int unsigned FRAC_BITS_DEF     = 14;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam int unsigned SQ_W    = 32;
  localparam int unsigned SQ_PAD  = 16;
  localparam int unsigned RAD_W   = SQ_W + SQ_PAD;
  localparam int unsigned LEN_W   = RAD_W / 2;
  localparam int unsigned REM_W   = LEN_W + 3;
  localparam int unsigned CZ_W    = 33;
  localparam int unsigned CORE_FRAC = 30;
  localparam int unsigned OUT_W   = 192;

  localparam logic signed [CZ_W-1:0] INV_GAIN = 33'sd652032874;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        angle;
    logic               nf;
  } item_t;

  typedef struct packed {
    item_t           item;
    logic [SQ_W-1:0] sq;
  } sq_side_t;

  typedef struct packed {
    item_t            item;
    logic             zero;
    logic [LEN_W-1:0] len;
  } div_side_t;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    quad_e              quad;
  } cor_side_t;

  function automatic logic signed [CZ_W-1:0] atan_turn(input logic [4:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      5'd24: v = 33'sd41;
      5'd25: v = 33'sd20;
      5'd26: v = 33'sd10;
      5'd27: v = 33'sd5;
      5'd28: v = 33'sd3;
      5'd29: v = 33'sd1;
      5'd30: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/aarm_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the integer square root per cell, digit by digit.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell #(
  parameter int unsigned PAIR = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  aarm_pkg::sq_side_t            side_i,
  input  logic [aarm_pkg::REM_W-1:0]    rem_i,
  input  logic [aarm_pkg::LEN_W-1:0]    root_i,
  output logic                          valid_o,
  output aarm_pkg::sq_side_t            side_o,
  output logic [aarm_pkg::REM_W-1:0]    rem_o,
  output logic [aarm_pkg::LEN_W-1:0]    root_o
);

  logic [aarm_pkg::RAD_W-1:0] rad;
  logic [1:0]                 pair;
  logic [aarm_pkg::REM_W-1:0] rem_sh;
  logic [aarm_pkg::REM_W-1:0] trial;
  logic                       ge;
  logic [aarm_pkg::REM_W-1:0] rem_d;
  logic [aarm_pkg::LEN_W-1:0] root_d;
  logic                       valid_q;
  aarm_pkg::sq_side_t         side_q;
  logic [aarm_pkg::REM_W-1:0] rem_q;
  logic [aarm_pkg::LEN_W-1:0] root_q;

  always_comb begin
    rad    = {side_i.sq, {aarm_pkg::SQ_PAD{1'b0}}};
    pair   = rad[2*PAIR +: 2];
    rem_sh = {rem_i[aarm_pkg::REM_W-3:0], pair};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[aarm_pkg::LEN_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

// ===== rtl/aarm_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit for each of the three axis components.
// ----------------------------------------------------------------------------
module aarm_div_cell #(
  parameter int unsigned NW  = 39,
  parameter int unsigned QW  = 16,
  parameter int unsigned BIT = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  aarm_pkg::div_side_t        side_i,
  input  logic [2:0][NW-1:0]         rem_i,
  input  logic [2:0][QW-1:0]         quot_i,
  output logic                       valid_o,
  output aarm_pkg::div_side_t        side_o,
  output logic [2:0][NW-1:0]         rem_o,
  output logic [2:0][QW-1:0]         quot_o
);

  logic [NW-1:0]         dvs;
  logic [2:0][NW-1:0]    rem_d;
  logic [2:0][QW-1:0]    quot_d;
  logic                  valid_q;
  aarm_pkg::div_side_t   side_q;
  logic [2:0][NW-1:0]    rem_q;
  logic [2:0][QW-1:0]    quot_q;

  always_comb begin
    dvs = NW'(side_i.len) << BIT;
    for (int l = 0; l < 3; l++) begin
      if (rem_i[l] >= dvs) begin
        rem_d[l]  = rem_i[l] - dvs;
        quot_d[l] = quot_i[l] | (QW'(1) << BIT);
      end else begin
        rem_d[l]  = rem_i[l];
        quot_d[l] = quot_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;

endmodule

// ===== rtl/aarm_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation of the sine and cosine vector.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  aarm_pkg::cor_side_t                side_i,
  input  logic signed [aarm_pkg::CZ_W-1:0]   x_i,
  input  logic signed [aarm_pkg::CZ_W-1:0]   y_i,
  input  logic signed [aarm_pkg::CZ_W-1:0]   z_i,
  output logic                               valid_o,
  output aarm_pkg::cor_side_t                side_o,
  output logic signed [aarm_pkg::CZ_W-1:0]   x_o,
  output logic signed [aarm_pkg::CZ_W-1:0]   y_o,
  output logic signed [aarm_pkg::CZ_W-1:0]   z_o
);

  logic signed [aarm_pkg::CZ_W-1:0] dx;
  logic signed [aarm_pkg::CZ_W-1:0] dy;
  logic signed [aarm_pkg::CZ_W-1:0] at;
  logic signed [aarm_pkg::CZ_W-1:0] x_d;
  logic signed [aarm_pkg::CZ_W-1:0] y_d;
  logic signed [aarm_pkg::CZ_W-1:0] z_d;
  logic                             valid_q;
  aarm_pkg::cor_side_t              side_q;
  logic signed [aarm_pkg::CZ_W-1:0] x_q;
  logic signed [aarm_pkg::CZ_W-1:0] y_q;
  logic signed [aarm_pkg::CZ_W-1:0] z_q;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    at = aarm_pkg::atan_turn(5'(IDX));
    if (!z_i[aarm_pkg::CZ_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - at;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== rtl/aarm_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix stages
// Quadrant correction of sine and cosine, then the Rodrigues products,
// rounding and saturation over six pipeline stages.
// ----------------------------------------------------------------------------
module aarm_matrix #(
  parameter int unsigned FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  aarm_pkg::cor_side_t                side_i,
  input  logic signed [aarm_pkg::CZ_W-1:0]   x_i,
  input  logic signed [aarm_pkg::CZ_W-1:0]   y_i,
  output logic                               valid_o,
  output logic [aarm_pkg::OUT_W-1:0]         data_o
);

  localparam int unsigned SH   = aarm_pkg::CORE_FRAC - FRAC_BITS;
  localparam int unsigned CW   = FRAC_BITS + 3;
  localparam int unsigned SW   = 16 + CW;
  localparam int unsigned PW   = 32 + CW;
  localparam int unsigned PW1  = PW + 1;
  localparam int unsigned RW   = PW1 - FRAC_BITS;
  localparam int unsigned DW   = CW + FRAC_BITS + 1;
  localparam int unsigned VW0  = (RW > SW) ? RW : SW;
  localparam int unsigned VW   = ((VW0 > DW) ? VW0 : DW) + 1;
  localparam int unsigned VW1  = VW + 1;
  localparam int unsigned FW   = VW1 - FRAC_BITS;

  localparam logic signed [33:0]    HALF_C = 34'((2 ** SH) >> 1);
  localparam logic signed [PW1-1:0] HALF_P = PW1'((2 ** FRAC_BITS) >> 1);
  localparam logic signed [VW1-1:0] HALF_V = VW1'((2 ** FRAC_BITS) >> 1);
  localparam logic signed [CW-1:0]  ONE_C  = CW'(2 ** FRAC_BITS);
  localparam logic signed [FW-1:0]  MAX_F  = FW'(32767);
  localparam logic signed [FW-1:0]  MIN_F  = -FW'(32768);

  logic [5:0] vld_q;

  // Quadrant correction.
  logic signed [33:0]   cr;
  logic signed [33:0]   sr;
  logic signed [CW-1:0] c0;
  logic signed [CW-1:0] s0;
  logic signed [CW-1:0] c_d;
  logic signed [CW-1:0] s_d;
  logic signed [CW-1:0] c_q;
  logic signed [CW-1:0] s_q;
  logic signed [15:0]   ax_q [3];

  always_comb begin
    cr = (34'(x_i) + HALF_C) >>> SH;
    sr = (34'(y_i) + HALF_C) >>> SH;
    c0 = cr[CW-1:0];
    s0 = sr[CW-1:0];
    case (side_i.quad)
      aarm_pkg::QUAD_1: begin
        c_d = -s0;
        s_d = c0;
      end
      aarm_pkg::QUAD_2: begin
        c_d = -c0;
        s_d = -s0;
      end
      aarm_pkg::QUAD_3: begin
        c_d = s0;
        s_d = -c0;
      end
      default: begin
        c_d = c0;
        s_d = s0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q      <= c_d;
      s_q      <= s_d;
      ax_q[0]  <= side_i.ux;
      ax_q[1]  <= side_i.uy;
      ax_q[2]  <= side_i.uz;
    end
  end

  // First products: xx, xy, xz, yy, yz, zz and the sine terms.
  logic signed [31:0]   p1_q [6];
  logic signed [SW-1:0] st1_q [3];
  logic signed [CW-1:0] c1_q;
  logic signed [CW-1:0] t1_q;
  logic signed [15:0]   ax1_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q[0] <= ax_q[0] * ax_q[0];
      p1_q[1] <= ax_q[0] * ax_q[1];
      p1_q[2] <= ax_q[0] * ax_q[2];
      p1_q[3] <= ax_q[1] * ax_q[1];
      p1_q[4] <= ax_q[1] * ax_q[2];
      p1_q[5] <= ax_q[2] * ax_q[2];
      for (int k = 0; k < 3; k++) begin
        st1_q[k] <= ax_q[k] * s_q;
        ax1_q[k] <= ax_q[k];
      end
      c1_q <= c_q;
      t1_q <= ONE_C - c_q;
    end
  end

  // Products with one minus cosine.
  logic signed [PW-1:0] p2_q [6];
  logic signed [SW-1:0] st2_q [3];
  logic signed [CW-1:0] c2_q;
  logic signed [15:0]   ax2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        p2_q[k] <= p1_q[k] * t1_q;
      end
      for (int k = 0; k < 3; k++) begin
        st2_q[k] <= st1_q[k];
        ax2_q[k] <= ax1_q[k];
      end
      c2_q <= c1_q;
    end
  end

  // Rounding of the products.
  logic signed [PW1-1:0] rnd3 [6];
  logic signed [RW-1:0]  r3_q [6];
  logic signed [SW-1:0]  st3_q [3];
  logic signed [CW-1:0]  c3_q;
  logic signed [15:0]    ax3_q [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      rnd3[k] = (PW1'(p2_q[k]) + HALF_P) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        r3_q[k] <= rnd3[k][RW-1:0];
      end
      for (int k = 0; k < 3; k++) begin
        st3_q[k] <= st2_q[k];
        ax3_q[k] <= ax2_q[k];
      end
      c3_q <= c2_q;
    end
  end

  // Entry sums before the final rounding.
  logic signed [VW-1:0] cd4;
  logic signed [VW-1:0] v4_q [9];
  logic signed [15:0]   ax4_q [3];

  assign cd4 = VW'(c3_q) <<< FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v4_q[0] <= cd4 + VW'(r3_q[0]);
      v4_q[1] <= VW'(r3_q[1]) - VW'(st3_q[2]);
      v4_q[2] <= VW'(r3_q[2]) + VW'(st3_q[1]);
      v4_q[3] <= VW'(r3_q[1]) + VW'(st3_q[2]);
      v4_q[4] <= cd4 + VW'(r3_q[3]);
      v4_q[5] <= VW'(r3_q[4]) - VW'(st3_q[0]);
      v4_q[6] <= VW'(r3_q[2]) - VW'(st3_q[1]);
      v4_q[7] <= VW'(r3_q[4]) + VW'(st3_q[0]);
      v4_q[8] <= cd4 + VW'(r3_q[5]);
      for (int k = 0; k < 3; k++) begin
        ax4_q[k] <= ax3_q[k];
      end
    end
  end

  // Final rounding and saturation.
  logic signed [VW1-1:0] rnd5 [9];
  logic signed [FW-1:0]  f5 [9];
  logic signed [15:0]    m5_d [9];
  logic signed [15:0]    m5_q [9];
  logic signed [15:0]    ax5_q [3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd5[k] = (VW1'(v4_q[k]) + HALF_V) >>> FRAC_BITS;
      f5[k]   = rnd5[k][FW-1:0];
      if (f5[k] > MAX_F) begin
        m5_d[k] = 16'sh7fff;
      end else if (f5[k] < MIN_F) begin
        m5_d[k] = 16'sh8000;
      end else begin
        m5_d[k] = f5[k][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        m5_q[k] <= m5_d[k];
      end
      for (int k = 0; k < 3; k++) begin
        ax5_q[k] <= ax4_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = {ax5_q[2], ax5_q[1], ax5_q[0],
                    m5_q[8], m5_q[7], m5_q[6], m5_q[5], m5_q[4],
                    m5_q[3], m5_q[2], m5_q[1], m5_q[0]};

endmodule

// ===== rtl/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// The path from accepted input word to output word runs through the square root, divider
// and CORDIC cell chains, then the matrix stages and the output register.
// Throughput: one word per cycle; a full skid entry stalls every cell and the input.
// A two-entry output buffer takes the last result while the output stalls.
// Reset is asynchronous and active low; it clears all valid flags, data is not reset.
// ----------------------------------------------------------------------------
// Axis-angle to rotation matrix
// Optional axis normalization, CORDIC sine and cosine, and the 3x3 Rodrigues
// rotation matrix in saturated fixed point, as one pipeline of cells.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int unsigned FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // axis_x[15:0], axis_y[31:16], axis_z[47:32], angle[63:48]
  input  logic [63:0]                 s_axis_tdata,
  // normalize_first[0]
  input  logic [0:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // m_r0_c0, m_r0_c1, m_r0_c2, m_r1_c0, m_r1_c1, m_r1_c2, m_r2_c0, m_r2_c1,
  // m_r2_c2, used_x, used_y, used_z, 16 bits each from bit 0 up
  output logic [aarm_pkg::OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned LW  = aarm_pkg::LEN_W;
  localparam int unsigned NW  = FRAC_BITS + 25;
  localparam int unsigned QW  = FRAC_BITS + 2;
  localparam int unsigned NV  = (QW + 1 > 17) ? QW + 1 : 17;
  localparam int unsigned NST = CORDIC_STAGES;

  localparam logic signed [15:0] ONE16 =
    (FRAC_BITS >= 15) ? 16'sh7fff : 16'(2 ** FRAC_BITS);
  localparam logic signed [NV-1:0] MAX_N = NV'(32767);
  localparam logic signed [NV-1:0] MIN_N = -NV'(32768);

  logic en;
  logic skid_vld_q;
  logic out_vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // Squares of the axis components.
  aarm_pkg::item_t    in_item;
  logic               s1_vld_q;
  aarm_pkg::item_t    s1_item_q;
  logic signed [31:0] s1_sq_q [3];
  logic               s2_vld_q;
  aarm_pkg::sq_side_t s2_side_q;

  assign in_item = '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                     z: s_axis_tdata[47:32], angle: s_axis_tdata[63:48],
                     nf: s_axis_tuser[0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q      <= in_item;
      s1_sq_q[0]     <= in_item.x * in_item.x;
      s1_sq_q[1]     <= in_item.y * in_item.y;
      s1_sq_q[2]     <= in_item.z * in_item.z;
      s2_side_q.item <= s1_item_q;
      s2_side_q.sq   <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
    end
  end

  // Square root chain.
  logic                        sq_vld  [0:LW];
  aarm_pkg::sq_side_t          sq_side [0:LW];
  logic [aarm_pkg::REM_W-1:0]  sq_rem  [0:LW];
  logic [LW-1:0]               sq_root [0:LW];

  assign sq_vld[0]  = s2_vld_q;
  assign sq_side[0] = s2_side_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    aarm_sqrt_cell #(
      .PAIR (LW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[j]),
      .side_i  (sq_side[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .valid_o (sq_vld[j+1]),
      .side_o  (sq_side[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1])
    );
  end

  // Dividend setup.
  logic signed [15:0]   raw [3];
  logic [15:0]          mag [3];
  logic [2:0][NW-1:0]   num;
  logic                 pp_vld_q;
  aarm_pkg::div_side_t  pp_side_q;
  logic [2:0][NW-1:0]   pp_num_q;

  assign raw[0] = sq_side[LW].item.x;
  assign raw[1] = sq_side[LW].item.y;
  assign raw[2] = sq_side[LW].item.z;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = raw[l][15] ? 16'(-raw[l]) : 16'(raw[l]);
      num[l] = (NW'(mag[l]) << (FRAC_BITS + 8)) + NW'(sq_root[LW] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_side_q.item <= sq_side[LW].item;
      pp_side_q.zero <= (sq_side[LW].sq == '0);
      pp_side_q.len  <= sq_root[LW];
      pp_num_q       <= num;
    end
  end

  // Divider chain.
  logic                 dv_vld  [0:QW];
  aarm_pkg::div_side_t  dv_side [0:QW];
  logic [2:0][NW-1:0]   dv_rem  [0:QW];
  logic [2:0][QW-1:0]   dv_quot [0:QW];

  assign dv_vld[0]  = pp_vld_q;
  assign dv_side[0] = pp_side_q;
  assign dv_rem[0]  = pp_num_q;
  assign dv_quot[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    aarm_div_cell #(
      .NW  (NW),
      .QW  (QW),
      .BIT (QW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[j]),
      .side_i  (dv_side[j]),
      .rem_i   (dv_rem[j]),
      .quot_i  (dv_quot[j]),
      .valid_o (dv_vld[j+1]),
      .side_o  (dv_side[j+1]),
      .rem_o   (dv_rem[j+1]),
      .quot_o  (dv_quot[j+1])
    );
  end

  // Axis selection and CORDIC start values.
  aarm_pkg::item_t     dv_item;
  logic signed [15:0]  draw [3];
  logic signed [NV-1:0] qv  [3];
  logic signed [NV-1:0] sv  [3];
  logic signed [15:0]  nrm [3];
  logic signed [15:0]  use_ax [3];
  logic [15:0]         ang_sum;
  aarm_pkg::quad_e     quad;
  logic [15:0]         resid;
  logic                ci_vld_q;
  aarm_pkg::cor_side_t ci_side_q;
  logic signed [aarm_pkg::CZ_W-1:0] ci_z_q;

  assign dv_item = dv_side[QW].item;
  assign draw[0] = dv_item.x;
  assign draw[1] = dv_item.y;
  assign draw[2] = dv_item.z;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qv[l] = NV'(dv_quot[QW][l]);
      sv[l] = draw[l][15] ? -qv[l] : qv[l];
      if (sv[l] > MAX_N) begin
        nrm[l] = 16'sh7fff;
      end else if (sv[l] < MIN_N) begin
        nrm[l] = 16'sh8000;
      end else begin
        nrm[l] = sv[l][15:0];
      end
    end
    if (!dv_item.nf) begin
      for (int l = 0; l < 3; l++) begin
        use_ax[l] = draw[l];
      end
    end else if (dv_side[QW].zero) begin
      use_ax[0] = ONE16;
      use_ax[1] = '0;
      use_ax[2] = '0;
    end else begin
      for (int l = 0; l < 3; l++) begin
        use_ax[l] = nrm[l];
      end
    end
    ang_sum = dv_item.angle + 16'h2000;
    quad    = aarm_pkg::quad_e'(ang_sum[15:14]);
    resid   = dv_item.angle - {ang_sum[15:14], 14'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ci_side_q.ux   <= use_ax[0];
      ci_side_q.uy   <= use_ax[1];
      ci_side_q.uz   <= use_ax[2];
      ci_side_q.quad <= quad;
      ci_z_q         <= {resid[15], resid, 16'b0};
    end
  end

  // CORDIC chain.
  logic                             co_vld  [0:NST];
  aarm_pkg::cor_side_t              co_side [0:NST];
  logic signed [aarm_pkg::CZ_W-1:0] co_x    [0:NST];
  logic signed [aarm_pkg::CZ_W-1:0] co_y    [0:NST];
  logic signed [aarm_pkg::CZ_W-1:0] co_z    [0:NST];

  assign co_vld[0]  = ci_vld_q;
  assign co_side[0] = ci_side_q;
  assign co_x[0]    = aarm_pkg::INV_GAIN;
  assign co_y[0]    = '0;
  assign co_z[0]    = ci_z_q;

  for (genvar j = 0; j < NST; j++) begin : g_cordic
    aarm_cordic_cell #(
      .IDX (j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (co_vld[j]),
      .side_i  (co_side[j]),
      .x_i     (co_x[j]),
      .y_i     (co_y[j]),
      .z_i     (co_z[j]),
      .valid_o (co_vld[j+1]),
      .side_o  (co_side[j+1]),
      .x_o     (co_x[j+1]),
      .y_o     (co_y[j+1]),
      .z_o     (co_z[j+1])
    );
  end

  // Matrix stages.
  logic                        mx_vld;
  logic [aarm_pkg::OUT_W-1:0]  mx_data;

  aarm_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (co_vld[NST]),
    .side_i  (co_side[NST]),
    .x_i     (co_x[NST]),
    .y_i     (co_y[NST]),
    .valid_o (mx_vld),
    .data_o  (mx_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      pp_vld_q <= 1'b0;
      ci_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      pp_vld_q <= sq_vld[LW];
      ci_vld_q <= dv_vld[QW];
    end
  end

  // Output register with skid entry.
  logic [aarm_pkg::OUT_W-1:0] out_q;
  logic [aarm_pkg::OUT_W-1:0] skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (mx_vld) begin
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (mx_vld) begin
      if (!out_vld_q || m_axis_tready) begin
        out_q <= mx_data;
      end else begin
        skid_q <= mx_data;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/aarm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix checker
// Port-level assertions on the stream handshakes and the output buffer.
// ----------------------------------------------------------------------------
module aarm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [aarm_pkg::OUT_W-1:0]  m_axis_tdata
);

  // The input side only closes after a stalled output word.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input ready dropped without an output stall");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // No output word right out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // While the input side is closed, the output word stays offered.
  a_closed_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input closed with no output word pending");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
